/* rtl/core/yuyv_downscale_to_bgr_core_assert.svh */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR core: assertion macros
// Shared property wrappers for the checkers of this block.
// ---------------------------------------------------------------------------
`ifndef YUYV_DOWNSCALE_TO_BGR_CORE_ASSERT_SVH
`define YUYV_DOWNSCALE_TO_BGR_CORE_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define YDS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define YDS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/ydsbgr_pkg.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR: shared package
// Register codes, field widths, reset values and the beat types passed
// between the sampler, the conversion lanes and the output merge.
// ---------------------------------------------------------------------------
package ydsbgr_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 2'd3;

    // Register field widths
    localparam int DIM_W  = 13;
    localparam int STEP_W = 16;

    // Register values after reset
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [STEP_W-1:0] RST_COLUMN_STEP  = 16'd4096;
    localparam logic [STEP_W-1:0] RST_ROW_STEP     = 16'd4096;

    // Output queue sizing (power of two)
    localparam int QUEUE_DEPTH = 16;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One pixel handed to a conversion lane
    typedef struct packed {
        logic       sel;
        logic [7:0] luma;
        logic [7:0] chroma_b;
        logic [7:0] chroma_r;
        logic       row_end;
        logic       frame_end;
    } t_lane_req;

    // One converted pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       frame_end;
    } t_pix;

    // Lane result
    typedef struct packed {
        logic sel;
        t_pix pix;
    } t_lane_rsp;

    // One output beat
    typedef struct packed {
        t_pix pix;
        logic last;
    } t_beat;

endpackage

/* rtl/core/ydsbgr_sampler.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR: sampler
// Holds the configuration and the raster counters, decides which of the
// two pixels of a macropixel are sampled and registers them for the lanes.
// ---------------------------------------------------------------------------
module ydsbgr_sampler #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int STEP_FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ydsbgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ydsbgr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  logic [7:0]                          i_luma_even,
    input  logic [7:0]                          i_chroma_blue,
    input  logic [7:0]                          i_luma_odd,
    input  logic [7:0]                          i_chroma_red,
    output logic [1:0]                          o_pick_cnt,
    output ydsbgr_pkg::t_lane_req               o_req_even,
    output ydsbgr_pkg::t_lane_req               o_req_odd
);

    localparam int STEP_SPAN = 2 ** (ydsbgr_pkg::STEP_W - STEP_FRAC_BITS);
    localparam int CI_W      = $clog2(MAX_WIDTH + STEP_SPAN);
    localparam int RI_W      = $clog2(MAX_HEIGHT + STEP_SPAN);
    localparam int CPOS_W    = CI_W + STEP_FRAC_BITS;
    localparam int RPOS_W    = RI_W + STEP_FRAC_BITS;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [13:0] MAX_W14   = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14   = 14'(MAX_HEIGHT);
    localparam logic [16:0] STEP_ONE  = 17'(1 << STEP_FRAC_BITS);

    // Effective width: clamped to the supported range, rounded down to even.
    function automatic logic [CI_W-1:0] f_eff_width(input logic [ydsbgr_pkg::DIM_W-1:0] raw);
        logic [13:0] t;
        t = {1'b0, raw};
        if (t < 14'd2) t = 14'd2;
        if (t > MAX_W14) t = MAX_W14;
        t[0] = 1'b0;
        return CI_W'(t);
    endfunction

    // Effective height: clamped to the supported range.
    function automatic logic [RI_W-1:0] f_eff_height(input logic [ydsbgr_pkg::DIM_W-1:0] raw);
        logic [13:0] t;
        t = {1'b0, raw};
        if (t < 14'd1) t = 14'd1;
        if (t > MAX_H14) t = MAX_H14;
        return RI_W'(t);
    endfunction

    // Effective step: never below one source pixel.
    function automatic logic [16:0] f_eff_step(input logic [ydsbgr_pkg::STEP_W-1:0] raw);
        logic [16:0] t;
        t = {1'b0, raw};
        if (t < STEP_ONE) t = STEP_ONE;
        return t;
    endfunction

    // Configuration, kept in effective form
    logic [CI_W-1:0]   r_width;
    logic [RI_W-1:0]   r_height;
    logic [CPOS_W-1:0] r_cstep;
    logic [RPOS_W-1:0] r_rstep;

    // Raster state
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CPOS_W-1:0] r_cpos, n_cpos;
    logic [RPOS_W-1:0] r_rpos, n_rpos;

    // Sampling decision
    logic [CI_W-1:0]   col_x, col_x1, col_x2;
    logic [RI_W-1:0]   row_x1;
    logic [CPOS_W-1:0] pos_a, pos_mid, pos_b;
    logic [RPOS_W-1:0] rpos_step;
    logic              row_sel, sel0, sel1, rend0, rend1, fend_row, wrap;

    // Registered lane requests
    logic [1:0]        r_sel;
    logic [1:0]        r_rend, r_fend;
    logic [7:0]        r_luma0, r_luma1, r_cb, r_cr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= f_eff_width(ydsbgr_pkg::RST_FRAME_WIDTH);
            r_height <= f_eff_height(ydsbgr_pkg::RST_FRAME_HEIGHT);
            r_cstep  <= CPOS_W'(f_eff_step(ydsbgr_pkg::RST_COLUMN_STEP));
            r_rstep  <= RPOS_W'(f_eff_step(ydsbgr_pkg::RST_ROW_STEP));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ydsbgr_pkg::CFG_FRAME_WIDTH: begin
                    r_width <= f_eff_width(i_cfg_data[ydsbgr_pkg::DIM_W-1:0]);
                end
                ydsbgr_pkg::CFG_FRAME_HEIGHT: begin
                    r_height <= f_eff_height(i_cfg_data[ydsbgr_pkg::DIM_W-1:0]);
                end
                ydsbgr_pkg::CFG_COLUMN_STEP: begin
                    r_cstep <= CPOS_W'(f_eff_step(i_cfg_data));
                end
                ydsbgr_pkg::CFG_ROW_STEP: begin
                    r_rstep <= RPOS_W'(f_eff_step(i_cfg_data));
                end
            endcase
        end
    end

    // Pick the sampled pixels and work out the next raster state.
    // A second sample in the same macropixel uses the position advanced by
    // the first one.
    always_comb begin
        col_x     = CI_W'(r_col);
        col_x1    = col_x + CI_W'(1);
        col_x2    = col_x + CI_W'(2);
        row_x1    = RI_W'(r_row) + RI_W'(1);
        row_sel   = (r_rpos[RPOS_W-1:STEP_FRAC_BITS] == RI_W'(r_row));
        sel0      = row_sel && (r_cpos[CPOS_W-1:STEP_FRAC_BITS] == col_x);
        pos_a     = r_cpos + r_cstep;
        pos_mid   = sel0 ? pos_a : r_cpos;
        sel1      = row_sel && (pos_mid[CPOS_W-1:STEP_FRAC_BITS] == col_x1);
        pos_b     = pos_mid + r_cstep;
        rpos_step = r_rpos + r_rstep;
        rend0     = (pos_a[CPOS_W-1:STEP_FRAC_BITS] >= r_width);
        rend1     = (pos_b[CPOS_W-1:STEP_FRAC_BITS] >= r_width);
        fend_row  = (rpos_step[RPOS_W-1:STEP_FRAC_BITS] >= r_height);
        wrap      = (col_x2 >= r_width);

        n_col  = COL_W'(col_x2);
        n_cpos = sel1 ? pos_b : pos_mid;
        n_row  = r_row;
        n_rpos = r_rpos;
        if (wrap) begin
            n_col  = '0;
            n_cpos = '0;
            if (row_sel) begin
                n_rpos = rpos_step;
            end
            if (row_x1 >= r_height) begin
                n_row  = '0;
                n_rpos = '0;
            end else begin
                n_row = ROW_W'(row_x1);
            end
        end

        o_pick_cnt = i_accept ? ({1'b0, sel0} + {1'b0, sel1}) : 2'd0;
    end

    // Raster state; any register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cpos <= '0;
            r_rpos <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cpos <= n_cpos;
            r_rpos <= n_rpos;
        end
    end

    // Lane request valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else begin
            r_sel <= i_accept ? {sel1, sel0} : 2'b00;
        end
    end

    // Lane request payload
    always_ff @(posedge i_clk) begin
        r_luma0 <= i_luma_even;
        r_luma1 <= i_luma_odd;
        r_cb    <= i_chroma_blue;
        r_cr    <= i_chroma_red;
        r_rend  <= {rend1, rend0};
        r_fend  <= {rend1 && fend_row, rend0 && fend_row};
    end

    always_comb begin
        o_req_even.sel       = r_sel[0];
        o_req_even.luma      = r_luma0;
        o_req_even.chroma_b  = r_cb;
        o_req_even.chroma_r  = r_cr;
        o_req_even.row_end   = r_rend[0];
        o_req_even.frame_end = r_fend[0];
        o_req_odd.sel        = r_sel[1];
        o_req_odd.luma       = r_luma1;
        o_req_odd.chroma_b   = r_cb;
        o_req_odd.chroma_r   = r_cr;
        o_req_odd.row_end    = r_rend[1];
        o_req_odd.frame_end  = r_fend[1];
    end

endmodule

/* rtl/core/ydsbgr_lane.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR: conversion lane
// Two-stage YUV to BGR conversion of one pixel: chroma products first,
// then the sums with clamping to 0..255.
// ---------------------------------------------------------------------------
module ydsbgr_lane #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ydsbgr_pkg::t_lane_req i_req,
    output ydsbgr_pkg::t_lane_rsp o_rsp
);

    // Coefficients rounded to nearest at elaboration
    localparam longint unsigned C_B  = ((64'd1770 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned C_GU = ((64'd343 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned C_GV = ((64'd714 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned C_R  = ((64'd1403 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;

    localparam int KW = COEF_FRAC_BITS + 2;
    localparam int PW = KW + 9;

    localparam logic signed [KW-1:0] K_B  = KW'(C_B);
    localparam logic signed [KW-1:0] K_GU = KW'(C_GU);
    localparam logic signed [KW-1:0] K_GV = KW'(C_GV);
    localparam logic signed [KW-1:0] K_R  = KW'(C_R);

    // Floor to integer and clamp to 0..255.
    function automatic logic [7:0] f_clamp(input logic signed [PW-1:0] acc);
        priority if (acc[PW-1]) begin
            return 8'd0;
        end else if (|acc[PW-2:COEF_FRAC_BITS+8]) begin
            return 8'd255;
        end else begin
            return acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
    endfunction

    logic signed [8:0]    du, dv;
    logic signed [PW-1:0] base, pb, pgu, pgv, pr;
    logic signed [PW-1:0] acc_b, acc_g, acc_r;

    logic                 r_a_sel;
    logic signed [PW-1:0] r_a_base, r_a_pb, r_a_pgu, r_a_pgv, r_a_pr;
    logic                 r_a_rend, r_a_fend;

    logic                 r_b_sel;
    ydsbgr_pkg::t_pix     r_b_pix;

    // Stage A: centered chroma times each coefficient
    always_comb begin
        du   = $signed({1'b0, i_req.chroma_b}) - 9'sd128;
        dv   = $signed({1'b0, i_req.chroma_r}) - 9'sd128;
        base = $signed(PW'({i_req.luma, {COEF_FRAC_BITS{1'b0}}}));
        pb   = PW'(K_B) * PW'(du);
        pgu  = PW'(K_GU) * PW'(du);
        pgv  = PW'(K_GV) * PW'(dv);
        pr   = PW'(K_R) * PW'(dv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_sel <= 1'b0;
        end else begin
            r_a_sel <= i_req.sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_base <= base;
        r_a_pb   <= pb;
        r_a_pgu  <= pgu;
        r_a_pgv  <= pgv;
        r_a_pr   <= pr;
        r_a_rend <= i_req.row_end;
        r_a_fend <= i_req.frame_end;
    end

    // Stage B: sums and clamp
    always_comb begin
        acc_b = r_a_base + r_a_pb;
        acc_g = r_a_base - r_a_pgu - r_a_pgv;
        acc_r = r_a_base + r_a_pr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_sel <= 1'b0;
        end else begin
            r_b_sel <= r_a_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_pix.blue      <= f_clamp(acc_b);
        r_b_pix.green     <= f_clamp(acc_g);
        r_b_pix.red       <= f_clamp(acc_r);
        r_b_pix.row_end   <= r_a_rend;
        r_b_pix.frame_end <= r_a_fend;
    end

    assign o_rsp.sel = r_b_sel;
    assign o_rsp.pix = r_b_pix;

endmodule

/* rtl/core/ydsbgr_merge.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR: output merge
// Writes the results of both lanes into a queue in pixel order, marks the
// final beat of each macropixel, and drives the output register. Slots are
// reserved when an item is accepted, so the queue never overflows.
// ---------------------------------------------------------------------------
module ydsbgr_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_pick_cnt,
    input  ydsbgr_pkg::t_lane_rsp i_rsp_even,
    input  ydsbgr_pkg::t_lane_rsp i_rsp_odd,
    input  logic                  i_out_stall,
    output logic                  o_busy,
    output logic                  o_out_valid,
    output ydsbgr_pkg::t_beat     o_beat
);

    localparam int QD  = ydsbgr_pkg::QUEUE_DEPTH;
    localparam int QAW = ydsbgr_pkg::QA_W;
    localparam int QCW = ydsbgr_pkg::QCNT_W;

    ydsbgr_pkg::t_beat r_q [QD];
    logic [QAW-1:0]    r_wp, r_rp, wp1;
    logic [QCW-1:0]    r_qcnt, r_used;
    logic [1:0]        n_wr;
    logic              load, out_acc;
    ydsbgr_pkg::t_beat beat_a, beat_b;
    logic              r_out_valid;
    ydsbgr_pkg::t_beat r_out;

    // Order the lane results: even pixel first, last flag on the final one.
    always_comb begin
        n_wr        = {1'b0, i_rsp_even.sel} + {1'b0, i_rsp_odd.sel};
        beat_a.pix  = i_rsp_even.sel ? i_rsp_even.pix : i_rsp_odd.pix;
        beat_a.last = !(i_rsp_even.sel && i_rsp_odd.sel);
        beat_b.pix  = i_rsp_odd.pix;
        beat_b.last = 1'b1;
        wp1         = r_wp + QAW'(1);
        out_acc     = r_out_valid && !i_out_stall;
        load        = (r_qcnt != '0) && (!r_out_valid || !i_out_stall);
        o_busy      = (r_used > QCW'(QD - 2));
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (n_wr != 2'd0) begin
            r_q[r_wp] <= beat_a;
        end
        if (n_wr == 2'd2) begin
            r_q[wp1] <= beat_b;
        end
    end

    // Pointers, fill count and reserved slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
            r_used <= '0;
        end else begin
            r_wp   <= r_wp + QAW'(n_wr);
            r_rp   <= r_rp + QAW'(load);
            r_qcnt <= r_qcnt + QCW'(n_wr) - QCW'(load);
            r_used <= r_used + QCW'(i_pick_cnt) - QCW'(out_acc);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_q[r_rp];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_beat      = r_out;

endmodule

/* rtl/core/yuyv_downscale_to_bgr_core.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR core
// Nearest-neighbor downscaler and YUV to BGR converter for a raster stream
// of YUYV macropixels.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per YUYV macropixel in raster order, taken at a
//   clock edge with i_in_valid high and o_in_stall low. Output channel: one
//   beat per sampled pixel (even pixel first), taken with o_out_valid high
//   and i_out_stall low; o_last marks the final beat of a macropixel.
//   Configuration: a write with i_cfg_valid high is taken at once
//   (o_cfg_ready stays high); every write restarts the frame. Write only
//   while no results are pending.
//   Path: a sampled pixel passes the sampler register, both stages of its
//   lane, the result queue and the output register on its way out.
//   Throughput: the two pixels go through two conversion lanes side by
//   side, and the output register moves one beat a cycle while i_out_stall
//   is low; new macropixels are taken while earlier ones are still in flight.
//   Stall: a 16-entry result queue absorbs backpressure; o_in_stall rises
//   when its free slots could not hold two more results.
//   Reset: synchronous, active low; registers return to 640 x 480 at unit
//   steps, the raster position to the frame start, and the queue empties.
// ---------------------------------------------------------------------------
module yuyv_downscale_to_bgr_core #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int STEP_FRAC_BITS = 12,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ydsbgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ydsbgr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Macropixel input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_luma_even,
    input  logic [7:0]                        i_chroma_blue,
    input  logic [7:0]                        i_luma_odd,
    input  logic [7:0]                        i_chroma_red,
    // Pixel output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_blue,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_red,
    output logic                              o_last,
    output logic                              o_row_end,
    output logic                              o_frame_end
);

    logic                  accept, cfg_we, busy;
    logic [1:0]            pick_cnt;
    ydsbgr_pkg::t_lane_req req_even, req_odd;
    ydsbgr_pkg::t_lane_rsp rsp_even, rsp_odd;
    ydsbgr_pkg::t_beat     beat;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;

    // Raster tracking and pixel selection
    ydsbgr_sampler #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_sampler (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_luma_even   (i_luma_even),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_odd    (i_luma_odd),
        .i_chroma_red  (i_chroma_red),
        .o_pick_cnt    (pick_cnt),
        .o_req_even    (req_even),
        .o_req_odd     (req_odd)
    );

    // Conversion lanes for the even and the odd pixel
    ydsbgr_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_even (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_even),
        .o_rsp   (rsp_even)
    );

    ydsbgr_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_odd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_odd),
        .o_rsp   (rsp_odd)
    );

    // Ordering, queueing and output register
    ydsbgr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pick_cnt  (pick_cnt),
        .i_rsp_even  (rsp_even),
        .i_rsp_odd   (rsp_odd),
        .i_out_stall (i_out_stall),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .o_beat      (beat)
    );

    assign o_blue      = beat.pix.blue;
    assign o_green     = beat.pix.green;
    assign o_red       = beat.pix.red;
    assign o_last      = beat.last;
    assign o_row_end   = beat.pix.row_end;
    assign o_frame_end = beat.pix.frame_end;

endmodule

/* rtl/core/ydsbgr_checker.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR: port checker
// Watches the output channel of the core and is bound to its top level.
// ---------------------------------------------------------------------------
`include "yuyv_downscale_to_bgr_core_assert.svh"

module ydsbgr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_blue,
    input logic [7:0] o_green,
    input logic [7:0] o_red,
    input logic       o_last,
    input logic       o_row_end,
    input logic       o_frame_end
);

    // A stalled beat stays offered and unchanged.
    `YDS_ASSERT_RUN(a_valid_held, o_out_valid && i_out_stall |=> o_out_valid, "output beat dropped while stalled")
    `YDS_ASSERT_RUN(a_beat_held, o_out_valid && i_out_stall |=> $stable(o_blue) && $stable(o_green) && $stable(o_red) && $stable(o_last) && $stable(o_row_end) && $stable(o_frame_end), "stalled output beat changed")

    // Reset empties the output register.
    `YDS_ASSERT_ANY(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // The frame ends on a row end, and nothing of the row follows its end.
    `YDS_ASSERT_RUN(a_frame_on_row, o_out_valid && o_frame_end |-> o_row_end, "frame end without row end")
    `YDS_ASSERT_RUN(a_row_end_last, o_out_valid && o_row_end |-> o_last, "row end not on final beat of its macropixel")

endmodule

bind yuyv_downscale_to_bgr_core ydsbgr_checker u_checker (.*);

/* tb/yuyv_downscale_to_bgr_core_tb.sv */
// ---------------------------------------------------------------------------
// YUYV downscale to BGR core testbench
// Drives YUYV macropixel beats and register writes into the core. A
// scoreboard holds the BGR pixels predicted for every accepted macropixel
// and checks each output beat against them in order. Both sides of the
// stream idle at random, the pixel sink stalls once for a long stretch,
// and the frame geometry and sampling steps change between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuyv_downscale_to_bgr_core_tb;

    localparam int     STEP_FRAC     = 12;
    localparam int     COEF_FRAC     = 16;
    localparam int     MAX_DIM       = 4096;
    localparam int     RANDOM_ITEMS  = 1650;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     CHOKE_CYCLES  = 300;
    localparam int     TAIL_CYCLES   = 20;
    localparam longint TIMEOUT_NS    = 64'd10_000_000;

    // Conversion gains in Q16, rounded to nearest
    localparam longint CB_GAIN = ((longint'(1770) << COEF_FRAC) + 500) / 1000;
    localparam longint GU_GAIN = ((longint'(343) << COEF_FRAC) + 500) / 1000;
    localparam longint GV_GAIN = ((longint'(714) << COEF_FRAC) + 500) / 1000;
    localparam longint CR_GAIN = ((longint'(1403) << COEF_FRAC) + 500) / 1000;

    typedef enum logic [1:0] {
        FEED_MACROPIXEL,
        FEED_REG_WRITE,
        FEED_FLUSH,
        FEED_BACKPRESSURE
    } t_feed_kind;

    typedef struct {
        t_feed_kind                        kind;
        logic [7:0]                        luma_even;
        logic [7:0]                        chroma_blue;
        logic [7:0]                        luma_odd;
        logic [7:0]                        chroma_red;
        logic [ydsbgr_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [ydsbgr_pkg::CFG_DATA_W-1:0] reg_data;
    } t_feed;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_valid   = 1'b0;
    logic                              o_cfg_ready;
    logic [ydsbgr_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [ydsbgr_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_stall;
    logic [7:0]                        i_luma_even   = '0;
    logic [7:0]                        i_chroma_blue = '0;
    logic [7:0]                        i_luma_odd    = '0;
    logic [7:0]                        i_chroma_red  = '0;
    logic                              o_out_valid;
    logic                              i_out_stall   = 1'b0;
    logic [7:0]                        o_blue;
    logic [7:0]                        o_green;
    logic [7:0]                        o_red;
    logic                              o_last;
    logic                              o_row_end;
    logic                              o_frame_end;

    yuyv_downscale_to_bgr_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_luma_even   (i_luma_even),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_odd    (i_luma_odd),
        .i_chroma_red  (i_chroma_red),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_blue        (o_blue),
        .o_green       (o_green),
        .o_red         (o_red),
        .o_last        (o_last),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end)
    );

    // Stimulus still to be sent and pixels still to be received.
    t_feed             feed_queue[$];
    ydsbgr_pkg::t_beat pending_pixels[$];

    // Predictor copy of the effective configuration and raster position.
    int        act_width;
    int        act_height;
    bit [15:0] act_hstep;
    bit [15:0] act_vstep;
    bit [12:0] cur_col;
    bit [12:0] cur_row;
    bit [24:0] col_mark;
    bit [24:0] row_mark;

    int   mismatch_count = 0;
    bit   stim_done      = 1'b0;
    logic choke_req      = 1'b0;
    logic choking        = 1'b0;

    // Sender and sink pacing.
    int send_gap   = 0;
    int settle     = 0;
    bit send_burst = 1'b0;
    int recv_gap   = 0;
    bit recv_burst = 1'b0;
    int choke_left = 0;
    bit choke_seen = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] clamp_q16(input longint acc);
        if (acc < 0)
            return 8'd0;
        if ((acc >>> COEF_FRAC) > 255)
            return 8'd255;
        return 8'(acc >>> COEF_FRAC);
    endfunction

    function automatic void restart_frame();
        cur_col  = '0;
        cur_row  = '0;
        col_mark = '0;
        row_mark = '0;
    endfunction

    // A write clamps the value to its legal range and restarts the frame.
    function automatic void apply_reg_write(input logic [ydsbgr_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [ydsbgr_pkg::CFG_DATA_W-1:0] data);
        int dim;
        case (idx)
            ydsbgr_pkg::CFG_FRAME_WIDTH: begin
                dim = int'(data[ydsbgr_pkg::DIM_W-1:0]);
                if (dim < 2) dim = 2;
                if (dim > MAX_DIM) dim = MAX_DIM;
                act_width = dim & ~1;
            end
            ydsbgr_pkg::CFG_FRAME_HEIGHT: begin
                dim = int'(data[ydsbgr_pkg::DIM_W-1:0]);
                if (dim < 1) dim = 1;
                if (dim > MAX_DIM) dim = MAX_DIM;
                act_height = dim;
            end
            ydsbgr_pkg::CFG_COLUMN_STEP: begin
                act_hstep = (data < (1 << STEP_FRAC)) ? 16'(1 << STEP_FRAC) : data;
            end
            ydsbgr_pkg::CFG_ROW_STEP: begin
                act_vstep = (data < (1 << STEP_FRAC)) ? 16'(1 << STEP_FRAC) : data;
            end
        endcase
        restart_frame();
    endfunction

    // Works out the sampled pixels of one macropixel, even pixel first,
    // and advances the raster position.
    function automatic void predict_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                               input logic [7:0] y1, input logic [7:0] v);
        logic [7:0]        lumas [2];
        longint            du;
        longint            dv;
        longint            base;
        bit                row_hit;
        int                fired;
        bit [25:0]         row_probe;
        ydsbgr_pkg::t_beat px;
        lumas[0] = y0;
        lumas[1] = y1;
        du = longint'(u) - 128;
        dv = longint'(v) - 128;
        fired = 0;

        if (int'(cur_row) >= act_height || int'(cur_col) >= act_width)
            restart_frame();
        row_hit = int'(row_mark >> STEP_FRAC) == int'(cur_row);

        for (int p = 0; p < 2; p++) begin
            if (row_hit && int'(col_mark >> STEP_FRAC) == int'(cur_col) + p) begin
                col_mark = col_mark + act_hstep;
                row_probe = row_mark + act_vstep;
                base = longint'(lumas[p]) << COEF_FRAC;
                px.pix.blue      = clamp_q16(base + CB_GAIN * du);
                px.pix.green     = clamp_q16(base - GU_GAIN * du - GV_GAIN * dv);
                px.pix.red       = clamp_q16(base + CR_GAIN * dv);
                px.pix.row_end   = int'(col_mark >> STEP_FRAC) >= act_width;
                px.pix.frame_end = px.pix.row_end
                                   && int'(row_probe >> STEP_FRAC) >= act_height;
                px.last          = 1'b0;
                pending_pixels.push_back(px);
                fired++;
            end
        end
        if (fired > 0)
            pending_pixels[pending_pixels.size()-1].last = 1'b1;

        // Step to the next macropixel; wrap rows and frames.
        cur_col = cur_col + 2;
        if (int'(cur_col) >= act_width) begin
            cur_col  = '0;
            col_mark = '0;
            if (row_hit)
                row_mark = row_mark + act_vstep;
            cur_row = cur_row + 1;
            if (int'(cur_row) >= act_height) begin
                cur_row  = '0;
                row_mark = '0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Pacing helpers
    // ------------------------------------------------------------------

    function automatic int draw_wait(input bit burst);
        if (burst || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic bit maybe_toggle(input bit mode);
        return ($urandom_range(0, 39) == 0) ? !mode : mode;
    endfunction

    // ------------------------------------------------------------------
    // Driver: macropixel beats and register writes from the feed queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic  offer;
        logic  write_req;
        t_feed head;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            choke_req   <= 1'b0;
            act_width   = int'(ydsbgr_pkg::RST_FRAME_WIDTH);
            act_height  = int'(ydsbgr_pkg::RST_FRAME_HEIGHT);
            act_hstep   = ydsbgr_pkg::RST_COLUMN_STEP;
            act_vstep   = ydsbgr_pkg::RST_ROW_STEP;
            restart_frame();
            send_gap = 0;
            settle   = 0;
        end else begin
            offer     = i_in_valid;
            write_req = i_cfg_valid;

            // A macropixel beat taken at this edge.
            if (i_in_valid && !o_in_stall) begin
                predict_macropixel(i_luma_even, i_chroma_blue, i_luma_odd, i_chroma_red);
                offer      = 1'b0;
                send_burst = maybe_toggle(send_burst);
                send_gap   = choking ? 0 : draw_wait(send_burst);
            end

            // A register write taken at this edge.
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                write_req = 1'b0;
            end

            // Fetch the next feed entry once the bus is free.
            if (!offer && !write_req) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (feed_queue.size() != 0) begin
                    head = feed_queue[0];
                    case (head.kind)
                        FEED_MACROPIXEL: begin
                            i_luma_even   <= head.luma_even;
                            i_chroma_blue <= head.chroma_blue;
                            i_luma_odd    <= head.luma_odd;
                            i_chroma_red  <= head.chroma_red;
                            offer = 1'b1;
                            void'(feed_queue.pop_front());
                        end
                        FEED_REG_WRITE: begin
                            // Write only once the core has drained and settled.
                            settle = (pending_pixels.size() == 0) ? settle + 1 : 0;
                            if (settle > SETTLE_CYCLES) begin
                                i_cfg_index <= head.reg_index;
                                i_cfg_data  <= head.reg_data;
                                write_req = 1'b1;
                                settle    = 0;
                                void'(feed_queue.pop_front());
                            end
                        end
                        FEED_FLUSH: begin
                            if (pending_pixels.size() == 0)
                                void'(feed_queue.pop_front());
                        end
                        FEED_BACKPRESSURE: begin
                            choke_req <= 1'b1;
                            void'(feed_queue.pop_front());
                        end
                    endcase
                end else begin
                    stim_done = 1'b1;
                end
            end

            i_in_valid  <= offer;
            i_cfg_valid <= write_req;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each pixel beat and drives the sink stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        ydsbgr_pkg::t_beat seen;
        ydsbgr_pkg::t_beat want;
        logic              hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            choking     <= 1'b0;
            recv_gap   = 0;
            choke_left = 0;
            choke_seen = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen.pix.blue      = o_blue;
                seen.pix.green     = o_green;
                seen.pix.red       = o_red;
                seen.pix.row_end   = o_row_end;
                seen.pix.frame_end = o_frame_end;
                seen.last          = o_last;
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected pixel beat b=%0d g=%0d r=%0d last=%0b row_end=%0b frame_end=%0b",
                                 $realtime, o_blue, o_green, o_red, o_last, o_row_end,
                                 o_frame_end);
                end else begin
                    want = pending_pixels.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: pixel mismatch expected b=%0d g=%0d r=%0d last=%0b row_end=%0b frame_end=%0b, got b=%0d g=%0d r=%0d last=%0b row_end=%0b frame_end=%0b",
                                     $realtime, want.pix.blue, want.pix.green,
                                     want.pix.red, want.last, want.pix.row_end,
                                     want.pix.frame_end, o_blue, o_green, o_red,
                                     o_last, o_row_end, o_frame_end);
                    end
                end
                recv_burst = maybe_toggle(recv_burst);
                recv_gap   = draw_wait(recv_burst);
            end

            // One long hold-off so the core fills and stalls its input.
            if (choke_req && !choke_seen) begin
                choke_seen = 1'b1;
                choke_left = CHOKE_CYCLES;
            end

            if (choke_left > 0) begin
                choke_left--;
                hold = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                hold = 1'b1;
            end else begin
                hold = 1'b0;
            end
            i_out_stall <= hold;
            choking     <= (choke_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                   input logic [7:0] y1, input logic [7:0] v);
        t_feed f;
        f = '{kind: FEED_MACROPIXEL, luma_even: y0, chroma_blue: u, luma_odd: y1,
              chroma_red: v, reg_index: '0, reg_data: '0};
        feed_queue.push_back(f);
    endtask

    task automatic push_reg_write(input logic [ydsbgr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ydsbgr_pkg::CFG_DATA_W-1:0] data);
        t_feed f;
        f = '{kind: FEED_REG_WRITE, luma_even: '0, chroma_blue: '0, luma_odd: '0,
              chroma_red: '0, reg_index: idx, reg_data: data};
        feed_queue.push_back(f);
    endtask

    task automatic push_marker(input t_feed_kind kind);
        t_feed f;
        f = '{kind: kind, luma_even: '0, chroma_blue: '0, luma_odd: '0,
              chroma_red: '0, reg_index: '0, reg_data: '0};
        feed_queue.push_back(f);
    endtask

    // Sample value with the extremes drawn more often than chance.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_random_macropixels(input int count);
        for (int k = 0; k < count; k++)
            push_macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // Frame dimension: mostly short frames, some longer, some raw 16-bit
    // values that exercise masking and clamping.
    function automatic logic [ydsbgr_pkg::CFG_DATA_W-1:0] pick_dimension(
        input int short_max,
        input int long_max
    );
        case ($urandom_range(0, 9))
            0:          return 16'($urandom_range(0, 65535));
            7, 8, 9:    return 16'($urandom_range(1, long_max));
            default:    return 16'($urandom_range(1, short_max));
        endcase
    endfunction

    // Sampling step: unit step often, below unit now and then, up to the top.
    function automatic logic [ydsbgr_pkg::CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:          return 16'($urandom_range(0, 4095));
            1, 2, 3:    return 16'd4096;
            8:          return 16'($urandom_range(12289, 65535));
            9:          return ($urandom_range(0, 1) == 0) ? 16'd65535 : 16'd0;
            default:    return 16'($urandom_range(4097, 12288));
        endcase
    endfunction

    initial begin
        int random_items;
        int count;
        bit opening_phase;

        // Color extremes at the reset geometry: clamping on every channel.
        push_macropixel(8'd0,   8'd0,   8'd255, 8'd0);
        push_macropixel(8'd255, 8'd255, 8'd0,   8'd255);
        push_macropixel(8'd0,   8'd128, 8'd255, 8'd128);
        push_macropixel(8'd255, 8'd0,   8'd0,   8'd255);
        push_macropixel(8'd128, 8'd255, 8'd128, 8'd0);
        push_macropixel(8'd1,   8'd127, 8'd254, 8'd129);
        push_macropixel(8'd170, 8'd85,  8'd85,  8'd170);
        push_macropixel(8'd85,  8'd170, 8'd170, 8'd85);

        // Width and height below range, steps below unit: one macropixel
        // per frame. Upper data bits of the width are ignored.
        push_reg_write(ydsbgr_pkg::CFG_FRAME_WIDTH,  16'hE001);
        push_reg_write(ydsbgr_pkg::CFG_FRAME_HEIGHT, 16'h0000);
        push_reg_write(ydsbgr_pkg::CFG_COLUMN_STEP,  16'h0000);
        push_reg_write(ydsbgr_pkg::CFG_ROW_STEP,     16'h0FFF);
        push_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
        push_macropixel(8'd0,   8'd0,   8'd0,   8'd0);
        push_macropixel(8'd200, 8'd60,  8'd30,  8'd220);

        // Dimensions above range and the largest steps: most macropixels
        // are skipped.
        push_reg_write(ydsbgr_pkg::CFG_FRAME_WIDTH,  16'h1FFF);
        push_reg_write(ydsbgr_pkg::CFG_FRAME_HEIGHT, 16'h1FFF);
        push_reg_write(ydsbgr_pkg::CFG_COLUMN_STEP,  16'hFFFF);
        push_reg_write(ydsbgr_pkg::CFG_ROW_STEP,     16'hFFFF);
        push_random_macropixels(4);

        // Odd width rounded down, fractional column step, two-row frame.
        push_reg_write(ydsbgr_pkg::CFG_FRAME_WIDTH,  16'd7);
        push_reg_write(ydsbgr_pkg::CFG_FRAME_HEIGHT, 16'd2);
        push_reg_write(ydsbgr_pkg::CFG_COLUMN_STEP,  16'h1800);
        push_reg_write(ydsbgr_pkg::CFG_ROW_STEP,     16'h1000);
        push_random_macropixels(6);

        // Random phases, each with fresh geometry and steps.
        random_items  = 0;
        opening_phase = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            if (opening_phase) begin
                // Unit steps keep every beat busy while the sink holds off.
                push_reg_write(ydsbgr_pkg::CFG_FRAME_WIDTH,  16'd64);
                push_reg_write(ydsbgr_pkg::CFG_FRAME_HEIGHT, 16'd8);
                push_reg_write(ydsbgr_pkg::CFG_COLUMN_STEP,  16'd4096);
                push_reg_write(ydsbgr_pkg::CFG_ROW_STEP,     16'd4096);
                push_marker(FEED_BACKPRESSURE);
                count = 120;
            end else begin
                push_reg_write(ydsbgr_pkg::CFG_FRAME_WIDTH,  pick_dimension(48, 700));
                push_reg_write(ydsbgr_pkg::CFG_FRAME_HEIGHT, pick_dimension(12, 40));
                push_reg_write(ydsbgr_pkg::CFG_COLUMN_STEP,  pick_step());
                push_reg_write(ydsbgr_pkg::CFG_ROW_STEP,     pick_step());
                count = $urandom_range(10, 120);
            end
            push_random_macropixels(count / 2);
            if (opening_phase || $urandom_range(0, 3) == 0)
                push_marker(FEED_FLUSH);
            push_random_macropixels(count - count / 2);
            random_items += count;
            opening_phase = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the feed to run dry and every pixel to come back.
        while (!stim_done)
            @(posedge i_clk);
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung stream.
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ydsbgr_pkg.sv
rtl/core/ydsbgr_sampler.sv
rtl/core/ydsbgr_lane.sv
rtl/core/ydsbgr_merge.sv
rtl/core/yuyv_downscale_to_bgr_core.sv
rtl/core/ydsbgr_checker.sv
tb/yuyv_downscale_to_bgr_core_tb.sv
